// File: hdl/assert_macros.svh
// Assertion macros for the RTL of the sorted insertion store.
// Defining ASSERT_OFF turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/sis_pkg.sv
// Package for the sorted insertion store: sizes, state type and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sis_pkg;

   localparam int DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_WIDTH = 4;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int IDX_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic insert;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rd_last;
   } status_type;

endpackage

// File: hdl/sis_ctrl.sv
// Controller of the sorted insertion store: item acceptance and readout sequencing.
// Depends on sis_pkg.
`timescale 1ns / 1ps

module sis_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               end_of_list,
   input  sis_pkg::status_type status,
   output logic               busy,
   output sis_pkg::cmd_type   cmd
);

   sis_pkg::state_type state_ff;
   sis_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sis_pkg::ST_IDLE: begin
            if (start && end_of_list) begin
               state_in = sis_pkg::ST_READ;
            end
         end
         sis_pkg::ST_READ: begin
            if (status.rd_last) begin
               state_in = sis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sis_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b0;
      cmd.insert = 1'b0;
      cmd.emit = 1'b0;
      unique case (state_ff)
         sis_pkg::ST_IDLE: begin
            cmd.insert = start;
         end
         sis_pkg::ST_READ: begin
            busy = 1'b1;
            cmd.emit = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/sis_datapath.sv
// Datapath of the sorted insertion store: row of compare-and-shift cells,
// fill count, overflow flag, readout index and result registers. Depends on sis_pkg.
`timescale 1ns / 1ps

module sis_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sis_pkg::cmd_type                        cmd,
   input  logic signed [sis_pkg::VALUE_WIDTH-1:0]  value,
   output sis_pkg::status_type                     status,
   output logic                                    rsp_valid,
   output logic signed [sis_pkg::VALUE_WIDTH-1:0]  rsp_sorted_value,
   output logic        [sis_pkg::POS_WIDTH-1:0]    rsp_position,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_dropped
);

   logic signed [sis_pkg::VALUE_WIDTH-1:0] cells_ff [sis_pkg::DEPTH];
   logic signed [sis_pkg::VALUE_WIDTH-1:0] cells_in [sis_pkg::DEPTH];
   logic [sis_pkg::DEPTH-1:0]              less;
   logic [sis_pkg::COUNT_WIDTH-1:0]        fill_ff;
   logic [sis_pkg::COUNT_WIDTH-1:0]        fill_in;
   logic                                   overflow_ff;
   logic                                   overflow_in;
   logic [sis_pkg::IDX_WIDTH-1:0]          rd_idx_ff;
   logic [sis_pkg::IDX_WIDTH-1:0]          rd_idx_in;
   logic                                   full;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic signed [sis_pkg::VALUE_WIDTH-1:0] rsp_value_ff;
   logic signed [sis_pkg::VALUE_WIDTH-1:0] rsp_value_in;
   logic [sis_pkg::POS_WIDTH-1:0]          rsp_pos_ff;
   logic [sis_pkg::POS_WIDTH-1:0]          rsp_pos_in;
   logic                                   rsp_last_ff;
   logic                                   rsp_last_in;
   logic                                   rsp_drop_ff;
   logic                                   rsp_drop_in;

   assign full = (fill_ff == sis_pkg::COUNT_WIDTH'(sis_pkg::DEPTH));

   // Each cell keeps its value, takes the new value, or takes its lower neighbor.
   always_comb begin
      for (int i = 0; i < sis_pkg::DEPTH; i++) begin
         less[i] = (sis_pkg::COUNT_WIDTH'(i) < fill_ff) && (cells_ff[i] < value);
      end
      for (int i = 0; i < sis_pkg::DEPTH; i++) begin
         if (less[i]) begin
            cells_in[i] = cells_ff[i];
         end else if (i == 0) begin
            cells_in[i] = value;
         end else if (less[(i == 0) ? 0 : i - 1]) begin
            cells_in[i] = value;
         end else begin
            cells_in[i] = cells_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      overflow_in = overflow_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.insert) begin
         rd_idx_in = '0;
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            fill_in = fill_ff + sis_pkg::COUNT_WIDTH'(1);
         end
      end else if (cmd.emit) begin
         rd_idx_in = rd_idx_ff + sis_pkg::IDX_WIDTH'(1);
      end
   end

   assign status.rd_last =
      ((sis_pkg::COUNT_WIDTH'(rd_idx_ff) + sis_pkg::COUNT_WIDTH'(1)) == fill_ff);

   always_comb begin
      rsp_valid_in = cmd.emit;
      rsp_value_in = cells_ff[rd_idx_ff];
      rsp_pos_in = sis_pkg::POS_WIDTH'(rd_idx_ff);
      rsp_last_in = status.rd_last;
      rsp_drop_in = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         overflow_ff <= 1'b0;
         rd_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         overflow_ff <= overflow_in;
         rd_idx_ff <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert && !full) begin
         for (int i = 0; i < sis_pkg::DEPTH; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
      if (cmd.emit) begin
         rsp_value_ff <= rsp_value_in;
         rsp_pos_ff <= rsp_pos_in;
         rsp_last_ff <= rsp_last_in;
         rsp_drop_ff <= rsp_drop_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_dropped = rsp_drop_ff;

endmodule

// File: hdl/sorted_insertion_store_unit.sv
// Top level of the sorted insertion store: controller plus datapath.
// Depends on sis_pkg, sis_ctrl, sis_datapath and assert_macros.svh.
//
//   channel   handshake        payload
//   request   start / busy     req_value, req_end_of_list
//   result    rsp_valid        rsp_sorted_value, rsp_position, rsp_last_of_run, rsp_dropped
//
// An item is inserted in the cycle it is accepted, so items may follow every cycle while
// busy is low. An item marked end of list is followed by one result per stored value,
// one per cycle, after the state and result registers. Busy rises in the cycle after
// acceptance, stays high while values are read out and drops as the last result shows.
// Reset is synchronous and empties the store and clears the dropped flag.
// Results are shown for one cycle each; the receiver cannot stall them.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_insertion_store_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [sis_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic                                    req_end_of_list,
   output logic                                    rsp_valid,
   output logic signed [sis_pkg::VALUE_WIDTH-1:0]  rsp_sorted_value,
   output logic        [sis_pkg::POS_WIDTH-1:0]    rsp_position,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_dropped
);

   sis_pkg::cmd_type    cmd;
   sis_pkg::status_type status;

   sis_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .end_of_list (req_end_of_list),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   sis_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .value            (req_value),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_position     (rsp_position),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_dropped      (rsp_dropped)
   );

   `ASSERT_NEXT(a_eol_starts_read, clock, reset, start && !busy && req_end_of_list, busy, "readout did not start")
   `ASSERT_NEXT(a_busy_emits, clock, reset, busy, rsp_valid, "readout cycle gave no item")
   `ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_last_of_run, !rsp_valid, "item after end of run")
   `ASSERT_SAME(a_mid_run_busy, clock, reset, rsp_valid && !rsp_last_of_run, busy, "run ended without last mark")
   `ASSERT_SAME(a_cmd_exclusive, clock, reset, cmd.emit, !cmd.insert, "insert during readout")

endmodule

// File: tb/tb.sv
// Self-checking testbench for sorted_insertion_store_unit: a stimulus table and random
// items, with every readout run compared against a typed row or an insertion-sort predictor.
// Depends on sis_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

   import sis_pkg::*;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]          position;
      logic                          last_of_run;
      logic                          dropped;
   } readout_t;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          end_of_list;
      logic                          typed;
      logic signed [VALUE_WIDTH-1:0] typed_value;
      logic                          typed_dropped;
   } stim_row_t;

   localparam int RANDOM_ITEMS = 200;
   localparam int QUIET_ITEMS  = 40;
   localparam logic signed [VALUE_WIDTH-1:0] MIN_VALUE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] MAX_VALUE = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          req_end_of_list;
   logic                          rsp_valid;
   logic signed [VALUE_WIDTH-1:0] rsp_sorted_value;
   logic [POS_WIDTH-1:0]          rsp_position;
   logic                          rsp_last_of_run;
   logic                          rsp_dropped;

   logic signed [VALUE_WIDTH-1:0] held_values [DEPTH];
   int                            held_count;
   logic                          held_overflow;
   readout_t                      pending_readout [$];
   int                            mismatch_count;
   stim_row_t                     directed_rows [19];

   sorted_insertion_store_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_end_of_list  (req_end_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_position     (rsp_position),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_dropped      (rsp_dropped)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic insert_and_read_out(input logic signed [VALUE_WIDTH-1:0] v,
                                      input logic eol, input bit record);
      int       slot;
      readout_t r;
      if (held_count >= DEPTH) begin
         held_overflow = 1'b1;
      end else begin
         slot = 0;
         while (slot < held_count && held_values[slot] < v) slot++;
         for (int i = held_count; i > slot; i--) held_values[i] = held_values[i-1];
         held_values[slot] = v;
         held_count++;
      end
      if (eol && record) begin
         for (int k = 0; k < held_count; k++) begin
            r.value       = held_values[k];
            r.position    = k[POS_WIDTH-1:0];
            r.last_of_run = (k + 1 == held_count);
            r.dropped     = held_overflow;
            pending_readout.push_back(r);
         end
      end
   endtask

   task automatic send_item(input logic signed [VALUE_WIDTH-1:0] v, input logic eol,
                            input bit record);
      req_value       <= v;
      req_end_of_list <= eol;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      insert_and_read_out(v, eol, record);
   endtask

   task automatic pause_sender(input bit quiet);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      readout_t want;
      if (!reset && rsp_valid) begin
         if (pending_readout.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result value=%0d pos=%0d last=%0b dropped=%0b", $time,
                     rsp_sorted_value, rsp_position, rsp_last_of_run, rsp_dropped);
         end else begin
            want = pending_readout.pop_front();
            if (rsp_sorted_value !== want.value || rsp_position !== want.position ||
                rsp_last_of_run !== want.last_of_run || rsp_dropped !== want.dropped) begin
               mismatch_count++;
               $display("%0t: expected value=%0d pos=%0d last=%0b dropped=%0b", $time,
                        want.value, want.position, want.last_of_run, want.dropped);
               $display("%0t:   actual value=%0d pos=%0d last=%0b dropped=%0b", $time,
                        rsp_sorted_value, rsp_position, rsp_last_of_run, rsp_dropped);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      logic signed [VALUE_WIDTH-1:0] v;
      readout_t                      r;
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_value       = '0;
      req_end_of_list = 1'b0;
      held_count      = 0;
      held_overflow   = 1'b0;
      mismatch_count  = 0;

      // The first row reads back a lone minimum from an empty store.
      directed_rows = '{
         '{MIN_VALUE,        1'b1, 1'b1, MIN_VALUE, 1'b0},
         '{MAX_VALUE,        1'b0, 1'b0, '0, 1'b0},
         '{32'sd0,           1'b0, 1'b0, '0, 1'b0},
         '{-32'sd1,          1'b0, 1'b0, '0, 1'b0},
         '{32'sd0,           1'b1, 1'b0, '0, 1'b0},
         '{MIN_VALUE,        1'b0, 1'b0, '0, 1'b0},
         '{MAX_VALUE,        1'b1, 1'b0, '0, 1'b0},
         '{32'sd1,           1'b0, 1'b0, '0, 1'b0},
         '{32'sh5555_5555,   1'b0, 1'b0, '0, 1'b0},
         '{32'shAAAA_AAAA,   1'b0, 1'b0, '0, 1'b0},
         '{32'sd100,         1'b0, 1'b0, '0, 1'b0},
         '{-32'sd100,        1'b0, 1'b0, '0, 1'b0},
         '{32'sd7,           1'b0, 1'b0, '0, 1'b0},
         '{32'sd7,           1'b0, 1'b0, '0, 1'b0},
         '{32'sd3,           1'b0, 1'b0, '0, 1'b0},
         '{32'sd2,           1'b1, 1'b0, '0, 1'b0},
         '{32'sd42,          1'b0, 1'b0, '0, 1'b0},
         '{MIN_VALUE,        1'b1, 1'b0, '0, 1'b0},
         '{32'sd0,           1'b1, 1'b0, '0, 1'b0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].value, directed_rows[i].end_of_list,
                   !directed_rows[i].typed);
         if (directed_rows[i].typed) begin
            r.value       = directed_rows[i].typed_value;
            r.position    = '0;
            r.last_of_run = 1'b1;
            r.dropped     = directed_rows[i].typed_dropped;
            pending_readout.push_back(r);
         end
         pause_sender(1'b0);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_readout.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 7))
            0:       v = MIN_VALUE;
            1:       v = MAX_VALUE;
            2:       v = $urandom_range(0, 15) - 8;
            default: v = $urandom();
         endcase
         send_item(v, $urandom_range(0, 5) == 0, 1'b1);
         pause_sender(n >= RANDOM_ITEMS - QUIET_ITEMS);
      end

      start <= 1'b0;
      while (pending_readout.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
